FILE: sv/tpsdg_pkg.sv
// shared constants, types and the cosine table builder for the three-phase duty generator
package tpsdg_pkg;

    localparam int PHASE_BITS_DEF = 32;

    // quarter-wave table, depth is a power of two
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int TAB_ADDR_BITS    = 10;
    localparam int TAB_IDX_W        = TAB_ADDR_BITS + 1;

    localparam int DUTY_FRAC_BITS = 16;
    localparam int DUTY_W         = DUTY_FRAC_BITS + 1;
    localparam int COS_W          = 17;
    localparam int AMP_W          = 17;
    localparam int PROD_W         = AMP_W + COS_W;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int STEP_W      = 32;
    localparam int PHASE_OUT_W = 32;
    localparam int CHAN_W      = 3;
    localparam int LEG_BITS    = 2;

    localparam logic [DUTY_W-1:0] DUTY_ONE  = DUTY_W'(1) << DUTY_FRAC_BITS;
    localparam logic [DUTY_W-1:0] DUTY_HALF = DUTY_W'(1) << (DUTY_FRAC_BITS - 1);
    localparam logic [AMP_W-1:0]  AMP_MAX   = AMP_W'(65536);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEST_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 2'd2;

    localparam logic [CFG_DATA_W-1:0] PHASE_STEP_RST = 32'd25770373;
    localparam logic [AMP_W-1:0]      AMPLITUDE_RST  = 17'd52429;

    // test channel codes
    localparam logic [CHAN_W-1:0] CH_U_FULL   = 3'd0;
    localparam logic [CHAN_W-1:0] CH_V_FULL   = 3'd1;
    localparam logic [CHAN_W-1:0] CH_W_FULL   = 3'd2;
    localparam logic [CHAN_W-1:0] CH_ALL_HALF = 3'd3;
    localparam logic [CHAN_W-1:0] CH_OFF      = 3'd4;
    localparam logic [CHAN_W-1:0] CH_SINE     = 3'd5;
    localparam logic [CHAN_W-1:0] CH_BUCK     = 3'd6;
    localparam logic [CHAN_W-1:0] CH_HOLD     = 3'd7;

    // leg slots, also the duty memory addresses
    localparam logic [LEG_BITS-1:0] LEG_U    = 2'd0;
    localparam logic [LEG_BITS-1:0] LEG_V    = 2'd1;
    localparam logic [LEG_BITS-1:0] LEG_W    = 2'd2;
    localparam logic [LEG_BITS-1:0] LEG_BUCK = 2'd3;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [7:0]  TAYLOR_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72,
                                                 8'd110, 8'd156, 8'd210};

    typedef struct packed {
        logic                vld;
        logic [LEG_BITS-1:0] leg;
        logic                tick;
    } leg_issue_t;

    typedef struct packed {
        logic                vld;
        logic [LEG_BITS-1:0] leg;
    } leg_res_t;

    typedef logic [COS_W-1:0] cos_tab_t [0:SINE_TABLE_DEPTH];

    // sin over a quarter turn in q16, taylor series in q30 evaluated at elaboration
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) >> TAB_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[k]);
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum + 64'd8192) >> 14;
            if (v > 64'd65536) begin
                v = 64'd65536;
            end
            tab[i] = v[COS_W-1:0];
        end
        return tab;
    endfunction

endpackage

FILE: sv/tpsdg_cos_rom.sv
// quarter-wave sine rom with a registered read port
module tpsdg_cos_rom (
    input  logic                           aclk,
    input  logic [tpsdg_pkg::TAB_IDX_W-1:0] rd_addr,
    output logic [tpsdg_pkg::COS_W-1:0]     rd_data
);
    import tpsdg_pkg::*;

    localparam cos_tab_t ROM = build_cos_tab();

    logic [COS_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        rd_data_reg <= ROM[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/tpsdg_leg_pipe.sv
// per-leg datapath: cosine lookup, held duty memory, scaling and write-back
module tpsdg_leg_pipe #(
    parameter int PHASE_BITS = tpsdg_pkg::PHASE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tpsdg_pkg::leg_issue_t           issue,
    input  logic [PHASE_BITS-1:0]           issue_phase,
    input  logic [tpsdg_pkg::CHAN_W-1:0]    test_channel,
    input  logic [tpsdg_pkg::AMP_W-1:0]     amplitude,
    output tpsdg_pkg::leg_res_t             res,
    output logic [tpsdg_pkg::DUTY_W-1:0]    res_duty,
    output logic [PHASE_BITS-1:0]           res_phase
);
    import tpsdg_pkg::*;

    localparam logic [63:0] LAG1_W = ((64'd1 << PHASE_BITS) + 64'd1) / 64'd3;
    localparam logic [63:0] LAG2_W = ((64'd1 << (PHASE_BITS + 1)) + 64'd1) / 64'd3;
    localparam logic [PHASE_BITS-1:0] LAG1 = LAG1_W[PHASE_BITS-1:0];
    localparam logic [PHASE_BITS-1:0] LAG2 = LAG2_W[PHASE_BITS-1:0];
    localparam int OFF_SHIFT = 33 - DUTY_FRAC_BITS;
    localparam logic [PROD_W-1:0] OFF_RND = PROD_W'(1) << (32 - DUTY_FRAC_BITS);
    localparam int MEM_DEPTH = 4;

    // issue stage
    logic [PHASE_BITS-1:0]    lag;
    logic [PHASE_BITS-1:0]    leg_phase;
    logic [1:0]               quad;
    logic [TAB_ADDR_BITS-1:0] rest;
    logic [TAB_IDX_W-1:0]     rom_addr;
    logic [COS_W-1:0]         cos_mag;

    // held duty memory
    logic [DUTY_W-1:0]    mem [0:MEM_DEPTH-1];
    logic [MEM_DEPTH-1:0] mem_vld_reg;
    logic [DUTY_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;
    logic [DUTY_W-1:0]    held1;

    // stage 1
    logic                  s1_vld_reg;
    logic [LEG_BITS-1:0]   s1_leg_reg;
    logic                  s1_tick_reg;
    logic                  s1_neg_reg;
    logic [PHASE_BITS-1:0] s1_phase_reg;

    // stage 2
    logic                  s2_vld_reg;
    logic [LEG_BITS-1:0]   s2_leg_reg;
    logic                  s2_tick_reg;
    logic                  s2_neg_reg;
    logic [PHASE_BITS-1:0] s2_phase_reg;
    logic [PROD_W-1:0]     s2_prod_reg;
    logic [DUTY_W-1:0]     s2_held_reg;

    logic [PROD_W-1:0] prod_rnd;
    logic [DUTY_W-1:0] offset;
    logic [DUTY_W-1:0] sine_duty;
    logic [DUTY_W-1:0] new_duty;

    always_comb begin
        unique case (issue.leg)
            LEG_V:   lag = LAG1;
            LEG_W:   lag = LAG2;
            default: lag = '0;
        endcase
    end

    assign leg_phase = issue_phase - lag;
    assign quad      = leg_phase[PHASE_BITS-1 -: 2];
    assign rest      = leg_phase[PHASE_BITS-3 -: TAB_ADDR_BITS];
    // quadrants 0 and 2 read the table mirrored
    assign rom_addr  = quad[0] ? {1'b0, rest}
                               : TAB_IDX_W'(SINE_TABLE_DEPTH) - {1'b0, rest};

    tpsdg_cos_rom u_cos_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (cos_mag)
    );

    always_ff @(posedge aclk) begin
        if (s2_vld_reg) begin
            mem[s2_leg_reg] <= new_duty;
        end
        rd_data_reg <= mem[issue.leg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (s2_vld_reg) begin
                mem_vld_reg[s2_leg_reg] <= 1'b1;
            end
            rd_vld_reg <= mem_vld_reg[issue.leg];
        end
    end

    // entries never written hold midscale
    assign held1 = rd_vld_reg ? rd_data_reg : DUTY_HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= issue.vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_leg_reg   <= issue.leg;
        s1_tick_reg  <= issue.tick;
        s1_neg_reg   <= quad[1] ^ quad[0];
        s1_phase_reg <= issue_phase;

        s2_leg_reg   <= s1_leg_reg;
        s2_tick_reg  <= s1_tick_reg;
        s2_neg_reg   <= s1_neg_reg;
        s2_phase_reg <= s1_phase_reg;
        s2_prod_reg  <= PROD_W'(amplitude) * PROD_W'(cos_mag);
        s2_held_reg  <= held1;
    end

    // offset rounds halves away from zero
    assign prod_rnd  = s2_prod_reg + OFF_RND;
    assign offset    = DUTY_W'(prod_rnd >> OFF_SHIFT);
    assign sine_duty = s2_neg_reg ? DUTY_HALF - offset : DUTY_HALF + offset;

    always_comb begin
        new_duty = s2_held_reg;
        if (s2_tick_reg) begin
            unique case (test_channel) inside
                CH_U_FULL, CH_V_FULL, CH_W_FULL: begin
                    new_duty = (s2_leg_reg == test_channel[LEG_BITS-1:0]) ? DUTY_ONE : '0;
                end
                CH_ALL_HALF: begin
                    new_duty = (s2_leg_reg != LEG_BUCK) ? DUTY_HALF : '0;
                end
                CH_OFF: begin
                    new_duty = '0;
                end
                CH_SINE: begin
                    new_duty = (s2_leg_reg != LEG_BUCK) ? sine_duty : s2_held_reg;
                end
                CH_BUCK: begin
                    new_duty = (s2_leg_reg == LEG_BUCK) ? DUTY_ONE : '0;
                end
                default: begin
                    new_duty = s2_held_reg;
                end
            endcase
        end
    end

    assign res.vld   = s2_vld_reg;
    assign res.leg   = s2_leg_reg;
    assign res_duty  = new_duty;
    assign res_phase = s2_phase_reg;

endmodule

FILE: sv/three_phase_sine_duty_generator.sv
// Three-phase sine duty generator: each accepted item (a control tick) yields one result with
// the U, V, W and buck duties in Q1.16 and the electrical angle. The leg sequencer issues the
// legs of an item in turn, U, V, W then buck, as the held duties live in a four-entry memory
// read one leg per cycle and the three cosine lookups share one ROM port; it can take the next
// item while issuing the buck leg. Each leg passes through the leg pipe, then the collection and
// output registers. A new item is taken while the previous result waits on the output register.
// The duty memory has per-entry valid bits, so there is no clearing pass after reset.
module three_phase_sine_duty_generator #(
    parameter int PHASE_BITS = tpsdg_pkg::PHASE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tpsdg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpsdg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_tick,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tpsdg_pkg::DUTY_W-1:0]      m_duty_u,
    output logic [tpsdg_pkg::DUTY_W-1:0]      m_duty_v,
    output logic [tpsdg_pkg::DUTY_W-1:0]      m_duty_w,
    output logic [tpsdg_pkg::DUTY_W-1:0]      m_duty_buck,
    output logic [tpsdg_pkg::PHASE_OUT_W-1:0] m_phase_out
);
    import tpsdg_pkg::*;

    logic [CHAN_W-1:0] test_channel_reg;
    logic [STEP_W-1:0] phase_step_reg;
    logic [AMP_W-1:0]  amplitude_reg;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [PHASE_BITS-1:0] step_scaled;

    logic                seq_busy_reg;
    logic [LEG_BITS-1:0] seq_leg_reg;
    logic                item_tick_reg;
    logic [1:0]          inflight_reg;

    logic s_accept;
    logic m_accept;
    logic seq_free;
    logic move_out;

    leg_issue_t            issue;
    leg_res_t              res;
    logic [DUTY_W-1:0]     res_duty;
    logic [PHASE_BITS-1:0] res_phase;

    logic [DUTY_W-1:0]     col_u_reg;
    logic [DUTY_W-1:0]     col_v_reg;
    logic [DUTY_W-1:0]     col_w_reg;
    logic [DUTY_W-1:0]     col_buck_reg;
    logic [PHASE_BITS-1:0] col_phase_reg;
    logic                  col_done_reg;

    logic                  m_valid_reg;
    logic [DUTY_W-1:0]     m_duty_u_reg;
    logic [DUTY_W-1:0]     m_duty_v_reg;
    logic [DUTY_W-1:0]     m_duty_w_reg;
    logic [DUTY_W-1:0]     m_duty_buck_reg;
    logic [PHASE_BITS-1:0] m_phase_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            test_channel_reg <= CH_U_FULL;
            phase_step_reg   <= PHASE_STEP_RST;
            amplitude_reg    <= AMPLITUDE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TEST_CHANNEL: test_channel_reg <= cfg_wdata[CHAN_W-1:0];
                REG_PHASE_STEP:   phase_step_reg   <= cfg_wdata[STEP_W-1:0];
                REG_AMPLITUDE: begin
                    if (cfg_wdata[AMP_W-1:0] <= AMP_MAX) begin
                        amplitude_reg <= cfg_wdata[AMP_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // step scaled to the accumulator width, sign kept
    generate
        if (PHASE_BITS >= STEP_W) begin : g_step_wide
            assign step_scaled = PHASE_BITS'($signed(phase_step_reg)) << (PHASE_BITS - STEP_W);
            assign m_phase_out = m_phase_reg[PHASE_BITS-1 -: PHASE_OUT_W];
        end else begin : g_step_narrow
            assign step_scaled = phase_step_reg[STEP_W-1 -: PHASE_BITS];
            assign m_phase_out = {m_phase_reg, {(PHASE_OUT_W - PHASE_BITS){1'b0}}};
        end
    endgenerate

    assign m_accept = m_valid_reg && m_ready;
    assign seq_free = !seq_busy_reg || (seq_leg_reg == LEG_BUCK);
    // room for one item in the output register and one in the leg pipe
    assign s_ready  = seq_free && ((inflight_reg < 2'd2) || m_accept);
    assign s_accept = s_valid && s_ready;

    assign phase_next = (s_tick && (test_channel_reg == CH_SINE)) ? phase_reg + step_scaled
                                                                  : phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            seq_busy_reg  <= 1'b0;
            seq_leg_reg   <= LEG_U;
            item_tick_reg <= 1'b0;
            inflight_reg  <= '0;
        end else begin
            if (s_accept) begin
                phase_reg     <= phase_next;
                seq_busy_reg  <= 1'b1;
                seq_leg_reg   <= LEG_U;
                item_tick_reg <= s_tick;
            end else if (seq_busy_reg) begin
                if (seq_leg_reg == LEG_BUCK) begin
                    seq_busy_reg <= 1'b0;
                end else begin
                    seq_leg_reg <= seq_leg_reg + 2'd1;
                end
            end
            inflight_reg <= inflight_reg + {1'b0, s_accept} - {1'b0, m_accept};
        end
    end

    assign issue.vld  = seq_busy_reg;
    assign issue.leg  = seq_leg_reg;
    assign issue.tick = item_tick_reg;

    tpsdg_leg_pipe #(
        .PHASE_BITS (PHASE_BITS)
    ) u_leg_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .issue        (issue),
        .issue_phase  (phase_reg),
        .test_channel (test_channel_reg),
        .amplitude    (amplitude_reg),
        .res          (res),
        .res_duty     (res_duty),
        .res_phase    (res_phase)
    );

    // gather the four legs of an item
    always_ff @(posedge aclk) begin
        if (res.vld) begin
            case (res.leg)
                LEG_U: col_u_reg <= res_duty;
                LEG_V: col_v_reg <= res_duty;
                LEG_W: col_w_reg <= res_duty;
                default: begin
                    col_buck_reg  <= res_duty;
                    col_phase_reg <= res_phase;
                end
            endcase
        end
    end

    assign move_out = col_done_reg && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_done_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (res.vld && (res.leg == LEG_BUCK)) begin
                col_done_reg <= 1'b1;
            end else if (move_out) begin
                col_done_reg <= 1'b0;
            end
            if (move_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_accept) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (move_out) begin
            m_duty_u_reg    <= col_u_reg;
            m_duty_v_reg    <= col_v_reg;
            m_duty_w_reg    <= col_w_reg;
            m_duty_buck_reg <= col_buck_reg;
            m_phase_reg     <= col_phase_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_duty_u    = m_duty_u_reg;
    assign m_duty_v    = m_duty_v_reg;
    assign m_duty_w    = m_duty_w_reg;
    assign m_duty_buck = m_duty_buck_reg;

`ifndef ASSERT_OFF
    a_inflight_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 2'd2)
        else $error("more than two items in flight");

    a_no_collect_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.vld && (res.leg == LEG_BUCK)) |-> !col_done_reg)
        else $error("finished item overwritten before reaching the output");

    a_accept_starts_u: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (seq_busy_reg && (seq_leg_reg == LEG_U)))
        else $error("accepted item did not start at leg u");

    a_out_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (inflight_reg != 2'd0))
        else $error("result shown with no item in flight");
`endif

endmodule

FILE: tb/sv/three_phase_sine_duty_generator_test.sv
// self-checking testbench for the three-phase sine duty generator
`timescale 1ns / 100ps

module three_phase_sine_duty_generator_test;
    import tpsdg_pkg::*;

    localparam int TAB_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic [31:0] LAG_THIRD = 32'(((64'd1 << 32) + 64'd1) / 64'd3);
    localparam logic [31:0] LAG_TWO_THIRDS = 32'(((64'd1 << 33) + 64'd1) / 64'd3);

    typedef struct packed {
        logic [DUTY_W-1:0] duty_u;
        logic [DUTY_W-1:0] duty_v;
        logic [DUTY_W-1:0] duty_w;
        logic [DUTY_W-1:0] duty_buck;
        logic [31:0]       angle;
    } duty_set_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_tick = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [DUTY_W-1:0]      m_duty_u;
    logic [DUTY_W-1:0]      m_duty_v;
    logic [DUTY_W-1:0]      m_duty_w;
    logic [DUTY_W-1:0]      m_duty_buck;
    logic [PHASE_OUT_W-1:0] m_phase_out;

    // predicted block state
    logic [CHAN_W-1:0] drv_channel = CH_U_FULL;
    logic [31:0]       drv_step = PHASE_STEP_RST;
    logic [AMP_W-1:0]  drv_amp = AMPLITUDE_RST;
    logic [31:0]       drv_phase = '0;
    logic [DUTY_W-1:0] held_u = DUTY_HALF;
    logic [DUTY_W-1:0] held_v = DUTY_HALF;
    logic [DUTY_W-1:0] held_w = DUTY_HALF;
    logic [DUTY_W-1:0] held_buck = DUTY_HALF;
    logic [16:0]       quarter_sine [0:TAB_DEPTH];

    duty_set_t pending_duties [$];

    int  ticks_sent = 0;
    int  results_seen = 0;
    int  reg_writes = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  long_stall_left = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;

    three_phase_sine_duty_generator uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_tick      (s_tick),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_duty_u    (m_duty_u),
        .m_duty_v    (m_duty_v),
        .m_duty_w    (m_duty_w),
        .m_duty_buck (m_duty_buck),
        .m_phase_out (m_phase_out)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // sin over a quarter turn in q16, series summed in q30 with truncated terms
    function automatic logic [16:0] sine_entry(input int i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned divisor;
        longint unsigned v;
        x = (QUARTER_TURN_Q30 * 64'(i)) / 64'(TAB_DEPTH);
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (int k = 1; k <= 7; k++) begin
            divisor = 64'((2 * k) * (2 * k + 1));
            term = ((term * x2) >> 30) / divisor;
            if (k % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        v = (acc + 64'd8192) >> 14;
        if (v > 64'd65536) begin
            v = 64'd65536;
        end
        return v[16:0];
    endfunction

    function automatic logic [DUTY_W-1:0] leg_duty(input logic [31:0] angle);
        logic [1:0]  quad;
        logic [9:0]  rest;
        logic [16:0] mag;
        logic [63:0] prod;
        logic [63:0] offset;
        quad = angle[31:30];
        rest = angle[29:20];
        if (quad == 2'd0 || quad == 2'd2) begin
            mag = quarter_sine[TAB_DEPTH - int'(rest)];
        end else begin
            mag = quarter_sine[rest];
        end
        prod = 64'(drv_amp) * 64'(mag);
        // half rounds away from zero on the magnitude
        offset = ((prod << DUTY_FRAC_BITS) + (64'd1 << 32)) >> 33;
        if (quad == 2'd1 || quad == 2'd2) begin
            return DUTY_HALF - offset[DUTY_W-1:0];
        end
        return DUTY_HALF + offset[DUTY_W-1:0];
    endfunction

    function automatic void hold_all(input logic [DUTY_W-1:0] u, v, w, b);
        held_u = u;
        held_v = v;
        held_w = w;
        held_buck = b;
    endfunction

    function automatic duty_set_t next_duties(input logic tick_bit);
        duty_set_t r;
        if (tick_bit) begin
            case (drv_channel)
                CH_U_FULL:   hold_all(DUTY_ONE, '0, '0, '0);
                CH_V_FULL:   hold_all('0, DUTY_ONE, '0, '0);
                CH_W_FULL:   hold_all('0, '0, DUTY_ONE, '0);
                CH_ALL_HALF: hold_all(DUTY_HALF, DUTY_HALF, DUTY_HALF, '0);
                CH_OFF:      hold_all('0, '0, '0, '0);
                CH_SINE: begin
                    drv_phase = drv_phase + drv_step;
                    held_u = leg_duty(drv_phase);
                    held_v = leg_duty(drv_phase - LAG_THIRD);
                    held_w = leg_duty(drv_phase - LAG_TWO_THIRDS);
                end
                CH_BUCK:     hold_all('0, '0, '0, DUTY_ONE);
                default: ;
            endcase
        end
        r.duty_u = held_u;
        r.duty_v = held_v;
        r.duty_w = held_w;
        r.duty_buck = held_buck;
        r.angle = drv_phase;
        return r;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            REG_TEST_CHANNEL: drv_channel = data[CHAN_W-1:0];
            REG_PHASE_STEP:   drv_step = data;
            REG_AMPLITUDE: begin
                if (data[AMP_W-1:0] <= AMP_MAX) begin
                    drv_amp = data[AMP_W-1:0];
                end
            end
            default: ;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        apply_reg(idx, data);
        reg_writes++;
    endtask

    task automatic send_tick(input logic tick_bit);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_tick <= tick_bit;
        do @(posedge aclk); while (!s_ready);
        pending_duties.push_back(next_duties(tick_bit));
        ticks_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_duties.size() != 0);
    endtask

    task automatic test_reset_state();
        send_tick(1'b0);
        send_tick(1'b1);
        wait_for_results();
    endtask

    task automatic test_fixed_patterns();
        logic [CHAN_W-1:0] pattern_seq [0:5];
        pattern_seq = '{CH_V_FULL, CH_W_FULL, CH_ALL_HALF, CH_OFF, CH_U_FULL, CH_BUCK};
        foreach (pattern_seq[i]) begin
            write_reg(REG_TEST_CHANNEL, 32'(pattern_seq[i]));
            send_tick(1'b1);
            wait_for_results();
        end
        // hold keeps the buck pattern
        write_reg(REG_TEST_CHANNEL, 32'(CH_HOLD));
        send_tick(1'b1);
        send_tick(1'b0);
        wait_for_results();
    endtask

    task automatic test_sine_extremes();
        write_reg(REG_TEST_CHANNEL, 32'(CH_SINE));
        send_tick(1'b1);
        send_tick(1'b1);
        wait_for_results();
        // quarter-turn steps wrap the accumulator
        write_reg(REG_AMPLITUDE, 32'd65536);
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        repeat (4) send_tick(1'b1);
        send_tick(1'b0);
        wait_for_results();
        write_reg(REG_AMPLITUDE, 32'd65537);
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_PHASE_STEP, 32'h7FFF_FFFF);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_for_results();
        write_reg(REG_PHASE_STEP, 32'h8000_0000);
        send_tick(1'b1);
        wait_for_results();
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(REG_AMPLITUDE, 32'd0);
        send_tick(1'b1);
        wait_for_results();
        write_reg(REG_PHASE_STEP, 32'd0);
        write_reg(REG_AMPLITUDE, 32'd1);
        send_tick(1'b1);
        wait_for_results();
    endtask

    task automatic test_output_stall();
        write_reg(REG_TEST_CHANNEL, 32'(CH_SINE));
        write_reg(REG_PHASE_STEP, 32'h0123_4567);
        write_reg(REG_AMPLITUDE, 32'd40000);
        tx_idle_en = 1'b0;
        long_stall_left = 80;
        repeat (24) send_tick(1'b1);
        wait_for_results();
        tx_idle_en = 1'b1;
    endtask

    task automatic randomize_config();
        logic [31:0] step_val;
        logic [31:0] amp_val;
        if ($urandom_range(0, 1)) begin
            write_reg(REG_TEST_CHANNEL, ($urandom & ~32'h7) | 32'(CH_SINE));
        end else begin
            write_reg(REG_TEST_CHANNEL, $urandom);
        end
        case ($urandom_range(0, 4))
            0: step_val = $urandom;
            1: step_val = $urandom_range(0, 32'h0400_0000);
            2: step_val = -$urandom_range(0, 32'h0400_0000);
            3: step_val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: step_val = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
        endcase
        write_reg(REG_PHASE_STEP, step_val);
        case ($urandom_range(0, 5))
            0: amp_val = 32'd0;
            1: amp_val = 32'd65536;
            2: amp_val = $urandom;
            3: amp_val = $urandom_range(65537, 131071);
            default: amp_val = $urandom_range(0, 65536);
        endcase
        write_reg(REG_AMPLITUDE, amp_val);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_UNUSED, $urandom);
        end
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 16; ph++) begin
            randomize_config();
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            repeat (50) send_tick($urandom_range(0, 9) != 0);
            wait_for_results();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // result side: random stall after each item while rx idles are enabled, plus a long hold-off set by the stall test
    initial begin : result_sink
        int  stall_left;
        logic ready_next;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                stall_left = rx_idle_en ? $urandom_range(0, 5) : 0;
            end
            if (long_stall_left > 0) begin
                long_stall_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_ready <= ready_next;
        end
    end

    function automatic void compare_field(input string label, input logic [31:0] want, got);
        if (got !== want) begin
            error_count++;
            if (error_count <= 10) begin
                $display("result %0d %s mismatch: expected %0d, got %0d",
                         results_seen, label, want, got);
            end
        end
    endfunction

    always @(posedge aclk) begin : result_check
        duty_set_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_duties.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("result %0d arrived with nothing outstanding", results_seen);
                end
            end else begin
                want = pending_duties.pop_front();
                compare_field("duty_u", 32'(want.duty_u), 32'(m_duty_u));
                compare_field("duty_v", 32'(want.duty_v), 32'(m_duty_v));
                compare_field("duty_w", 32'(want.duty_w), 32'(m_duty_w));
                compare_field("duty_buck", 32'(want.duty_buck), 32'(m_duty_buck));
                compare_field("phase_out", want.angle, m_phase_out);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILURE");
        $finish;
    end

    initial begin
        for (int i = 0; i <= TAB_DEPTH; i++) begin
            quarter_sine[i] = sine_entry(i);
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_fixed_patterns();
        test_sine_extremes();
        test_output_stall();
        test_random_phases();
        wait_for_results();
        repeat (16) @(posedge aclk);
        $display("%0d ticks, %0d results checked, %0d register writes, %0d errors",
                 ticks_sent, results_seen, reg_writes, error_count);
        $display("all channel codes, sine step and depth extremes, dropped writes, long stall");
        if (error_count == 0 && pending_duties.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
